// ----- rtl/core/itrs_pkg.sv -----
// Shared types, constants and character mapping for the integer-to-radix converter.
`default_nettype none

package itrs_pkg;

    localparam int VAL_W         = 32;
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int BITS_PER_CYC  = 8;
    localparam int CYC_PER_DIGIT = VAL_W / BITS_PER_CYC;
    localparam int STEP_W        = $clog2(CYC_PER_DIGIT);
    localparam int MAX_DIGITS    = VAL_W;
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W        = 3;
    localparam int PDATA_W       = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    localparam logic [ADDR_W-1:0] ADDR_RADIX = 3'd0;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture magnitude and sign of a new value
        logic div_step;   // run one step of the digit divider
        logic div_last;   // final cycle of a digit: push the remainder
        logic emit_sign;  // put '-' in the output register
        logic emit_pop;   // pop the top digit into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic radix_ok;   // radix lies in 2..36
        logic neg_dec;    // negative value in base 10
        logic quot_zero;  // quotient after this division cycle is zero
        logic cnt_one;    // one digit left on the stack
        logic out_free;   // output register can take a character
    } t_ctrl_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < DEC_BASE) begin
            digit_char = CHAR_ZERO + d_ext;
        end else begin
            digit_char = CHAR_UPPER + d_ext - {{(CHAR_W-RADIX_W){1'b0}}, DEC_BASE};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itrs_ctrl.sv -----
// Controller state machine: sequences load, digit division and character output.
`default_nettype none

module itrs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  itrs_pkg::t_ctrl_sts i_sts,
    output itrs_pkg::t_ctrl_cmd o_cmd
);
    import itrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                step_last;

    assign step_last = (r_step == STEP_W'(CYC_PER_DIGIT - 1));
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    if (i_sts.radix_ok) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (step_last) begin
                    o_cmd.div_last = 1'b1;
                    if (i_sts.quot_zero) begin
                        n_state = i_sts.neg_dec ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pop = 1'b1;
                    if (i_sts.cnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/itrs_datapath.sv -----
// Datapath: magnitude divider, digit stack and output character register.
`default_nettype none

module itrs_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [itrs_pkg::RADIX_W-1:0]       i_radix,
    input  wire  signed [itrs_pkg::VAL_W-1:0]  i_value,
    input  itrs_pkg::t_ctrl_cmd                i_cmd,
    output itrs_pkg::t_ctrl_sts                o_sts,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [itrs_pkg::CHAR_W-1:0]        o_char_code,
    output logic                               o_last
);
    import itrs_pkg::*;

    logic [VAL_W-1:0]    r_quot;
    logic [RADIX_W-1:0]  r_rem;
    logic                r_neg;
    logic [RADIX_W-1:0]  r_stack [MAX_DIGITS];
    logic [CNT_W-1:0]    r_count;

    logic [VAL_W-1:0]    quot_n;
    logic [RADIX_W-1:0]  rem_n;
    logic [VAL_W-1:0]    mag;
    logic                out_free;

    assign mag      = i_value[VAL_W-1] ? (~i_value + 1'b1) : i_value;
    assign out_free = !o_valid || i_ready;

    // Restoring division, several quotient bits per cycle; remainder stays below radix.
    always_comb begin
        logic [RADIX_W:0]   trial;
        logic [VAL_W-1:0]   q;
        logic [RADIX_W-1:0] r;
        q = r_quot;
        r = r_rem;
        for (int b = 0; b < BITS_PER_CYC; b++) begin
            trial = {r, q[VAL_W-1]};
            q     = {q[VAL_W-2:0], 1'b0};
            if (trial >= {1'b0, i_radix}) begin
                trial = trial - {1'b0, i_radix};
                q[0]  = 1'b1;
            end
            r = trial[RADIX_W-1:0];
        end
        quot_n = q;
        rem_n  = r;
    end

    assign o_sts.radix_ok  = (i_radix >= RADIX_MIN) && (i_radix <= RADIX_MAX);
    assign o_sts.neg_dec   = r_neg && (i_radix == DEC_BASE);
    assign o_sts.quot_zero = (quot_n == '0);
    assign o_sts.cnt_one   = (r_count == CNT_W'(1));
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= mag;
            r_rem  <= '0;
            r_neg  <= i_value[VAL_W-1];
        end else if (i_cmd.div_step) begin
            r_quot <= quot_n;
            r_rem  <= i_cmd.div_last ? '0 : rem_n;
        end
    end

    // Digit stack: entry 0 is the top; push shifts down, pop shifts up.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && i_cmd.div_last) begin
            r_stack[0] <= rem_n;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.emit_pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.div_step && i_cmd.div_last) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.emit_pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_pop) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            o_char_code <= CHAR_MINUS;
            o_last      <= 1'b0;
        end else if (i_cmd.emit_pop) begin
            o_char_code <= digit_char(r_stack[0]);
            o_last      <= (r_count == CNT_W'(1));
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_radix_string.sv -----
// Top level of the integer-to-radix text converter with its register port.
`default_nettype none

// Converts one signed 32-bit value per input transfer into ASCII text in the
// base held in the radix register (byte address 0, 6 bits, reset 10), most
// significant character first, digits above 9 as 'A'..'Z'. Negative values
// are shown by their magnitude; base 10 adds a leading '-'. The last
// character of each string carries o_last. A radix outside 2..36 drops the
// value without output. The divider retires 8 quotient bits per cycle; an
// item is loaded, divided by the radix once per digit with each remainder
// pushed on the digit stack, then popped one character at a time into the
// output register while the output side keeps taking transfers. A new value is
// taken once the last character has entered the output register.
module integer_to_radix_string (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // value input channel
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  signed [itrs_pkg::VAL_W-1:0]  i_value,
    // character output channel
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [itrs_pkg::CHAR_W-1:0]        o_char_code,
    output logic                               o_last,
    // register port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [itrs_pkg::ADDR_W-1:0]        paddr,
    input  wire  [itrs_pkg::PDATA_W-1:0]       pwdata,
    output logic [itrs_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import itrs_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    t_ctrl_cmd          cmd;
    t_ctrl_sts          sts;

    // Register port: pready is always high; keep only the low 6 bits of a write.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIX) ? {{(PDATA_W-RADIX_W){1'b0}}, r_radix} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_RADIX)) begin
            r_radix <= pwdata[RADIX_W-1:0];
        end
    end

    itrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itrs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/itrs_checker.sv -----
// Port-level checks for the integer-to-radix converter and their binding.
`default_nettype none

module itrs_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_ready,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire [itrs_pkg::CHAR_W-1:0]   o_char_code,
    input wire                          o_last
);
    import itrs_pkg::*;

    // A stalled character holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_code) && $stable(o_last))
        else $error("output changed while stalled");

    // The sign never ends a string.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CHAR_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    // While a string is unfinished, no new value is taken.
    a_busy_mid_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input ready in the middle of a string");

    // The block only goes busy after an input transfer.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(i_valid))
        else $error("busy without an input transfer");

    // Only digits, upper-case letters and the minus sign come out.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS)
                 || ((o_char_code >= CHAR_ZERO) && (o_char_code <= 7'h39))
                 || ((o_char_code >= CHAR_UPPER) && (o_char_code <= 7'h5A)))
        else $error("character outside the digit set");

endmodule

bind integer_to_radix_string itrs_checker u_itrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the integer-to-radix text converter.
`timescale 1ns / 100ps

module tb;

    import itrs_pkg::*;

    // One character of the expected text: ASCII code and end-of-string flag.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    // Output-side acceptance patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_pattern;

    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;  // address 4: no register there

    // Cycles to let pass before a register write once the text queue is empty.
    // It must cover the slowest value, which is a base-2 conversion.
    localparam int SETTLE_CYCLES = 200;

    // Longest correct stretch without any transfer: one settle wait before a
    // register write. Take that several times over.
    localparam int WATCHDOG_LIMIT = 5000;

    localparam int PHASE_ITEMS = 30;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [VAL_W-1:0]     i_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [CHAR_W-1:0]    o_char_code;
    logic                 o_last;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Text still owed by the block, oldest character first.
    t_text_char           expected_text[$];
    // Radix as the block should hold it.
    logic [RADIX_W-1:0]   cur_radix = RADIX_RESET;

    int                   n_errors     = 0;
    int                   quiet_cycles = 0;

    // Sender shaping: bursts of random length with gaps in between.
    bit                   tx_gaps_on = 1'b0;
    int                   burst_left = 0;
    bit                   valid_up   = 1'b0;

    // Receiver shaping.
    t_rx_pattern          rx_mode   = RX_ALWAYS;
    int                   rx_phase  = 0;
    int                   rx_period = 0;
    int                   rx_hold   = 0;

    integer_to_radix_string u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected text for one value in the current radix. Push nothing for a
    // radix outside 2..36, since the block drops the value.
    // ------------------------------------------------------------------
    function automatic void predict_text(input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0]  mag;
        logic [VAL_W-1:0]  base;
        logic [VAL_W-1:0]  d;
        logic [CHAR_W-1:0] digits[$];
        t_text_char        ch;
        if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX)
            return;
        base = {{(VAL_W-RADIX_W){1'b0}}, cur_radix};
        // Two's complement magnitude; the most negative value maps to 2^31.
        mag = value[VAL_W-1] ? (~value + 1'b1) : value;
        do begin
            d = mag % base;
            if (d < 10)
                digits.push_front(CHAR_ZERO + d[CHAR_W-1:0]);
            else
                digits.push_front(CHAR_UPPER + d[CHAR_W-1:0] - 7'd10);
            mag = mag / base;
        end while (mag != 0);
        // Only decimal text carries a sign.
        if (value[VAL_W-1] && cur_radix == DEC_BASE) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        foreach (digits[i]) begin
            ch.code = digits[i];
            ch.last = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    // Random value weighted toward the interesting corners of the current base.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [63:0]      p;
        logic [VAL_W-1:0] v;
        int               k;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 1000);
            4:       v = 32'd0 - $urandom_range(1, 1000);
            5: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h0000_0001;
                    3:       v = 32'h7FFF_FFFF;
                    4:       v = 32'h8000_0000;
                    default: v = 32'h8000_0001;
                endcase
            end
            6: begin
                // Land on or next to a power of the base, where the digit count steps.
                p = 64'd1;
                k = $urandom_range(1, 31);
                if (cur_radix >= RADIX_MIN) begin
                    repeat (k) begin
                        if (p * cur_radix > 64'h8000_0000)
                            break;
                        p = p * cur_radix;
                    end
                end
                v = p[VAL_W-1:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = 32'd0 - v;
            end
            7:       v = $urandom >> $urandom_range(0, 31);
            default: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one value, hold it until the transfer, then maybe open a gap.
    task automatic send_value(input logic [VAL_W-1:0] value);
        int gap;
        i_valid  <= 1'b1;
        i_value  <= value;
        valid_up = 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_text(value);
        if (tx_gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                // Mostly short gaps, now and then one longer than a whole digit loop.
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                i_valid  <= 1'b0;
                i_value  <= $urandom;
                valid_up = 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(0, 6);
            end
        end
    endtask

    task automatic drop_valid();
        if (valid_up) begin
            i_valid  <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic wait_text_done();
        while (expected_text.size() != 0)
            @(posedge i_clk);
    endtask

    // Bring the block to rest: stop offering, drain, then let a dropped value finish.
    task automatic go_idle();
        drop_valid();
        wait_text_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        go_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIX)
            cur_radix = data[RADIX_W-1:0];
        // Leave the bus idle before the next access.
        @(posedge i_clk);
    endtask

    // Read back the radix and check it against the tracked copy.
    task automatic check_radix_readback();
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RADIX;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[RADIX_W-1:0] !== cur_radix) begin
            $error("radix: expected %0d, got %0d", cur_radix, rd[RADIX_W-1:0]);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        case (rx_mode)
            RX_ALWAYS: i_ready <= 1'b1;
            RX_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                // Hold ready low for the tail of each period; reshape every period.
                if (rx_phase == 0) begin
                    rx_period = $urandom_range(2, 12);
                    rx_hold   = $urandom_range(1, rx_period - 1);
                    rx_phase  = rx_period;
                end
                i_ready <= (rx_phase > rx_hold);
                rx_phase--;
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_text.size() == 0) begin
                $error("char_code: expected nothing, got %0d (last %0b)", o_char_code, o_last);
                n_errors++;
            end else begin
                want = expected_text.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Count cycles with no transfer on any port; a hang ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Decimal out of reset: signs, zero and the 32-bit extremes.
    task automatic test_reset_decimal();
        check_radix_readback();
        rx_mode    = RX_ALWAYS;
        tx_gaps_on = 1'b0;
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd0 - 32'd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1234567890);
    endtask

    // Smallest and largest base, plus hex: longest and widest-digit text.
    task automatic test_radix_limits();
        rx_mode = RX_RANDOM;
        reg_write(ADDR_RADIX, 32'd2);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        reg_write(ADDR_RADIX, 32'd36);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'd0 - 32'd36);
        send_value(32'h7FFF_FFFF);
        reg_write(ADDR_RADIX, 32'd16);
        send_value(32'd0 - 32'd255);
        send_value(32'h7FFF_FFFF);
    endtask

    // Bases outside 2..36 drop values; upper data bits and unmapped
    // addresses leave the radix alone.
    task automatic test_register_edges();
        logic [RADIX_W-1:0] bad[4];
        bad = '{6'd0, 6'd1, 6'd37, 6'd63};
        rx_mode = RX_PERIODIC;
        foreach (bad[i]) begin
            reg_write(ADDR_RADIX, {{(PDATA_W-RADIX_W){1'b0}}, bad[i]});
            check_radix_readback();
            send_value(32'h8000_0000);
        end
        // Keep only the low six bits: this lands on base 8.
        reg_write(ADDR_RADIX, 32'hFFFF_FFC8);
        check_radix_readback();
        send_value(32'd0 - 32'd8);
        reg_write(ADDR_UNMAPPED, 32'd2);
        check_radix_readback();
        send_value(32'd64);
    endtask

    // Long random streams across bases, with both sides idling in turn.
    task automatic test_random_bases();
        int                 bases[13];
        logic [RADIX_W-1:0] r;
        bases = '{2, 36, 10, 16, 3, 35, 8, 10, 2, -1, 7, 36, -1};
        foreach (bases[i]) begin
            r = (bases[i] < 0) ? RADIX_W'($urandom_range(2, 36)) : bases[i][RADIX_W-1:0];
            reg_write(ADDR_RADIX, {{(PDATA_W-RADIX_W){1'b0}}, r});
            rx_mode    = t_rx_pattern'(i % 3);
            tx_gaps_on = (i % 4 != 0);
            burst_left = $urandom_range(0, 6);
            repeat (PHASE_ITEMS) send_value(pick_value());
            // Drop in an out-of-range base now and then; these values vanish.
            if (i % 5 == 4) begin
                r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                         : RADIX_W'($urandom_range(37, 63));
                reg_write(ADDR_RADIX, {{(PDATA_W-RADIX_W){1'b0}}, r});
                repeat (5) send_value($urandom);
            end
        end
    endtask

    // Stop the input side until the text has fully drained, then resume.
    task automatic test_pause_until_drained();
        reg_write(ADDR_RADIX, {{(PDATA_W-RADIX_W){1'b0}}, 6'($urandom_range(2, 36))});
        rx_mode    = RX_RANDOM;
        tx_gaps_on = 1'b0;
        repeat (5) begin
            repeat (4) send_value(pick_value());
            drop_valid();
            wait_text_done();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_decimal();
        test_radix_limits();
        test_register_edges();
        test_random_bases();
        test_pause_until_drained();

        go_idle();
        if (expected_text.size() != 0) begin
            $error("char_code: %0d characters never arrived", expected_text.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
